// File: sv/lcd_glyph_segment_writer_defines.svh
// Assertion macros for the segment writer checker.
// Depends on nothing; every use sits in a module with aclk and aresetn.
`ifndef LCD_GLYPH_SEGMENT_WRITER_DEFINES_SVH
`define LCD_GLYPH_SEGMENT_WRITER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define LGSW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lgsw assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define LGSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lgsw assertion failed");

`endif

// File: sv/lgsw_pkg.sv
// Shared types, constants and glyph tables of the segment writer.
// Depends on nothing.
package lgsw_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       show_point;
        logic       show_colon;
    } glyph_req_t;

    localparam logic [2:0] DIGIT_POS_1 = 3'd1;
    localparam logic [2:0] DIGIT_POS_2 = 3'd2;
    localparam logic [2:0] DIGIT_POS_3 = 3'd3;
    localparam logic [2:0] DIGIT_POS_4 = 3'd4;
    localparam logic [2:0] DIGIT_POS_5 = 3'd5;
    localparam logic [2:0] DIGIT_POS_6 = 3'd6;

    localparam logic [31:0] KEEP_POS_1       = 32'hCFFF_FFFC;
    localparam logic [31:0] KEEP_POS_2       = 32'hF3FF_FF03;
    localparam logic [31:0] KEEP_POS_3       = 32'hFCFF_FCFF;
    localparam logic [31:0] KEEP_POS_4       = 32'hFFCF_F3FF;
    localparam logic [31:0] KEEP_POS_5_UPPER = 32'hFFF3_EFFF;
    localparam logic [31:0] KEEP_POS_5_LOWER = 32'hFFF3_CFFF;
    localparam logic [31:0] KEEP_POS_6       = 32'hFFFC_3FFF;
    localparam logic [31:0] KEEP_BARS        = 32'hFFFF_5FFF;

    localparam logic [31:0] BAR_HIGH = 32'h0000_8000;
    localparam logic [31:0] BAR_LOW  = 32'h0000_2000;

    localparam logic [15:0] SEG_POINT = 16'h0002;
    localparam logic [15:0] SEG_COLON = 16'h0020;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_LOWER_M  = 8'h6D;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_ALL      = 8'hFF;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

    localparam logic [15:0] GLYPH_BLANK    = 16'h0000;
    localparam logic [15:0] GLYPH_STAR     = 16'hA0DD;
    localparam logic [15:0] GLYPH_MICRO    = 16'h6084;
    localparam logic [15:0] GLYPH_LOWER_M  = 16'hB210;
    localparam logic [15:0] GLYPH_LOWER_N  = 16'h2210;
    localparam logic [15:0] GLYPH_MINUS    = 16'hA000;
    localparam logic [15:0] GLYPH_SLASH    = 16'h00C0;
    localparam logic [15:0] GLYPH_PERCENT  = 16'hB300;
    localparam logic [15:0] GLYPH_ALL      = 16'hFFDD;

    localparam logic [15:0] CAP_TABLE [26] = '{
        16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
        16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
        16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
        16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
    };

    localparam logic [15:0] NUM_TABLE [10] = '{
        16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
        16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
    };

endpackage

// File: sv/lgsw_glyph_encoder.sv
// Character byte to 16-bit segment code, with point and colon overlay.
// Depends on lgsw_pkg for the request type and glyph tables.
module lgsw_glyph_encoder
    import lgsw_pkg::*;
(
    input  glyph_req_t  req,
    output logic [15:0] code
);

    logic [7:0]  digit_ofs;
    logic [7:0]  upper_ofs;
    logic [7:0]  lower_ofs;
    logic [15:0] base;

    assign digit_ofs = req.char_code - CH_DIGIT_0;
    assign upper_ofs = req.char_code - CH_UPPER_A;
    assign lower_ofs = req.char_code - CH_LOWER_A;

    always_comb begin
        case (req.char_code)
            CH_SPACE:    base = GLYPH_BLANK;
            CH_STAR:     base = GLYPH_STAR;
            CH_QUESTION: base = GLYPH_MICRO;
            CH_LOWER_M:  base = GLYPH_LOWER_M;
            CH_LOWER_N:  base = GLYPH_LOWER_N;
            CH_MINUS:    base = GLYPH_MINUS;
            CH_SLASH:    base = GLYPH_SLASH;
            CH_PERCENT:  base = GLYPH_PERCENT;
            CH_ALL:      base = GLYPH_ALL;
            default: begin
                if (req.char_code inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
                    base = NUM_TABLE[digit_ofs[3:0]];
                end else if (req.char_code inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
                    base = CAP_TABLE[upper_ofs[4:0]];
                end else if (req.char_code inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
                    base = CAP_TABLE[lower_ofs[4:0]];
                end else begin
                    base = GLYPH_BLANK;
                end
            end
        endcase
    end

    assign code = base | (req.show_point ? SEG_POINT : 16'h0000)
                       | (req.show_colon ? SEG_COLON : 16'h0000);

endmodule

// File: sv/lgsw_nibble_placer.sv
// Merges one segment nibble into a display word at a digit position.
// Depends on lgsw_pkg for position codes and keep masks.
module lgsw_nibble_placer
    import lgsw_pkg::*;
(
    input  logic [31:0] word_in,
    input  logic [3:0]  nibble,
    input  logic [2:0]  digit_position,
    input  logic        upper,
    output logic [31:0] word_out
);

    logic [31:0] n32;
    logic [31:0] n32_low;

    assign n32     = {28'd0, nibble};
    assign n32_low = upper ? (n32 & 32'h1) : (n32 & 32'h3);

    always_comb begin
        case (digit_position)
            DIGIT_POS_1: word_out = (word_in & KEEP_POS_1)
                                  | ((n32 & 32'hC) << 26) | (n32 & 32'h3);
            DIGIT_POS_2: word_out = (word_in & KEEP_POS_2)
                                  | ((n32 & 32'hC) << 24) | ((n32 & 32'h2) << 6)
                                  | ((n32 & 32'h1) << 2);
            DIGIT_POS_3: word_out = (word_in & KEEP_POS_3)
                                  | ((n32 & 32'hC) << 22) | ((n32 & 32'h3) << 8);
            DIGIT_POS_4: word_out = (word_in & KEEP_POS_4)
                                  | ((n32 & 32'hC) << 18) | ((n32 & 32'h3) << 10);
            DIGIT_POS_5: word_out = (word_in & (upper ? KEEP_POS_5_UPPER : KEEP_POS_5_LOWER))
                                  | ((n32 & 32'hC) << 16) | (n32_low << 12);
            DIGIT_POS_6: word_out = (word_in & KEEP_POS_6)
                                  | ((n32 & 32'h4) << 15) | ((n32 & 32'h8) << 13)
                                  | (n32_low << 14);
            default:     word_out = word_in;
        endcase
    end

endmodule

// File: sv/lcd_glyph_segment_writer.sv
// Fourteen-segment character writer: input register, then glyph lookup and masked merge
// into the display-word registers. Throughput one transaction per cycle unless m_tready
// stalls it; the single lookup-and-merge pass sets it.
// The result is the display-word register itself, held while m_tready is low.
// aresetn (synchronous) clears the display words, bar_reg and both valid flags.
module lcd_glyph_segment_writer
    import lgsw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic [3:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] char_code, [8] show_point, [9] show_colon, [12:10] digit_position
    input  logic [15:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] word_zero, [63:32] word_two, [95:64] word_four, [127:96] word_six
    output logic [127:0] m_tdata
);

    logic              in_valid_reg;
    glyph_req_t        req_reg;
    logic [2:0]        pos_reg;
    logic              out_valid_reg;
    logic [3:0]        bar_reg;
    logic [31:0]       words_reg [4];
    logic [31:0]       words_next [4];
    logic [31:0]       placed [4];
    logic [15:0]       code;
    logic              advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    lgsw_glyph_encoder u_encoder (
        .req  (req_reg),
        .code (code)
    );

    for (genvar w = 0; w < 4; w++) begin : g_word
        lgsw_nibble_placer u_placer (
            .word_in        (words_reg[w]),
            .nibble         (code[15 - 4 * w -: 4]),
            .digit_position (pos_reg),
            .upper          (w >= 2),
            .word_out       (placed[w])
        );
    end

    always_comb begin
        words_next[0] = placed[0];
        words_next[1] = placed[1];
        words_next[2] = (placed[2] & KEEP_BARS) | (bar_reg[1] ? BAR_HIGH : 32'd0)
                                                | (bar_reg[3] ? BAR_LOW  : 32'd0);
        words_next[3] = (placed[3] & KEEP_BARS) | (bar_reg[0] ? BAR_HIGH : 32'd0)
                                                | (bar_reg[2] ? BAR_LOW  : 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bar_reg       <= 4'd0;
            for (int i = 0; i < 4; i++) begin
                words_reg[i] <= 32'd0;
            end
        end else begin
            if (cfg_wen) begin
                bar_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    for (int i = 0; i < 4; i++) begin
                        words_reg[i] <= words_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg.char_code  <= s_tdata[7:0];
            req_reg.show_point <= s_tdata[8];
            req_reg.show_colon <= s_tdata[9];
            pos_reg            <= s_tdata[12:10];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {words_reg[3], words_reg[2], words_reg[1], words_reg[0]};

endmodule

// File: sv/lgsw_checker.sv
// Port-level checks of the segment writer, bound to the top level.
// Depends on lcd_glyph_segment_writer_defines.svh for the assertion macros.
`include "lcd_glyph_segment_writer_defines.svh"

module lgsw_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    `LGSW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LGSW_ASSERT_IMPL(a_stall_only_on_back, !s_tready, m_tvalid && !m_tready)
    `LGSW_ASSERT_IMPL(a_result_follows, s_tvalid && s_tready, ##2 m_tvalid)
    `LGSW_ASSERT_IMPL(a_unused_bits_zero, 1'b1,
        m_tdata[31:30] == 2'b00 && m_tdata[63:62] == 2'b00 &&
        m_tdata[95:94] == 2'b00 && m_tdata[127:126] == 2'b00)

endmodule

bind lcd_glyph_segment_writer lgsw_checker u_lgsw_checker (.*);
